[sv/wfmsc_pkg.sv]
// wfmsc_pkg: types, codes and small tables for the wavetable fm sound channel
// depends on nothing; used by wfmsc_ctrl, wfmsc_dp and the core top level
`timescale 1ns / 1ps
`default_nettype none

package wfmsc_pkg;

	// item function codes
	localparam logic [1:0] FUNC_TICK  = 2'd0;
	localparam logic [1:0] FUNC_WRITE = 2'd1;
	localparam logic [1:0] FUNC_READ  = 2'd2;

	// bus map
	localparam logic [15:0] ADDR_WAVE_FIRST = 16'h4040;
	localparam logic [15:0] ADDR_WAVE_LAST  = 16'h407F;
	localparam logic [15:0] ADDR_VOL_ENV    = 16'h4080;
	localparam logic [15:0] ADDR_PITCH_LO   = 16'h4082;
	localparam logic [15:0] ADDR_PITCH_HI   = 16'h4083;
	localparam logic [15:0] ADDR_GAIN_ENV   = 16'h4084;
	localparam logic [15:0] ADDR_MOD_CNT    = 16'h4085;
	localparam logic [15:0] ADDR_MOD_LO     = 16'h4086;
	localparam logic [15:0] ADDR_MOD_HI     = 16'h4087;
	localparam logic [15:0] ADDR_MOD_TABLE  = 16'h4088;
	localparam logic [15:0] ADDR_WAVE_CTRL  = 16'h4089;
	localparam logic [15:0] ADDR_ENV_SPEED  = 16'h408A;

	// bit positions in the control flag register
	localparam int FLG_VOL_DIS   = 0;
	localparam int FLG_VOL_GROW  = 1;
	localparam int FLG_WAV_HALT  = 2;
	localparam int FLG_ENV_HALT  = 3;
	localparam int FLG_GAIN_DIS  = 4;
	localparam int FLG_GAIN_GROW = 5;
	localparam int FLG_MOD_DIS   = 6;
	localparam int FLG_WAV_WRITE = 7;

	localparam int TABLE_DEPTH = 64;
	localparam int TABLE_AW    = 6;

	localparam logic [2:0] STEP_RESET = 3'd4;

	typedef struct packed {
		logic [1:0]  func;
		logic [15:0] bus_addr;
		logic [7:0]  bus_data;
	} in_item_t;

	typedef struct packed {
		logic [10:0] audio_level;
		logic [7:0]  read_data;
	} out_item_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ENV,
		ST_MOD,
		ST_MUL1,
		ST_MUL2,
		ST_PHASE,
		ST_LEVEL,
		ST_SCALE,
		ST_BUS,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic accept;
		logic env;
		logic modstep;
		logic mul1;
		logic mul2;
		logic phase;
		logic level;
		logic scale;
		logic bus;
		logic load_out;
	} ctrl_cmd_t;

	typedef struct packed {
		logic silent;
	} dp_status_t;

	function automatic logic signed [3:0] step_delta(input logic [2:0] step);
		logic signed [3:0] d;
		case (step)
			3'd0: d = 4'sd0;
			3'd1: d = 4'sd1;
			3'd2: d = 4'sd2;
			3'd3: d = 4'sd4;
			3'd5: d = -4'sd4;
			3'd6: d = -4'sd3;
			3'd7: d = -4'sd1;
			default: d = 4'sd0;
		endcase
		return d;
	endfunction

	// master attenuation as a fraction of 256
	function automatic logic [8:0] atten_mult(input logic [1:0] sel);
		logic [8:0] m;
		case (sel)
			2'd0: m = 9'd256;
			2'd1: m = 9'd171;
			2'd2: m = 9'd128;
			2'd3: m = 9'd102;
			default: m = 9'd256;
		endcase
		return m;
	endfunction

endpackage

`default_nettype wire

[sv/wavetable_fm_sound_channel_core.sv]
// wavetable fm sound channel core: one item at a time through a sequencer and datapath
// a tick steps env, mod, mul1, mul2, phase, level, scale, done (env, mod, done when halted
// or in wave write); a bus write or read steps bus, done; an unused code goes to done
// the tick length is set by the two dependent bend multiplies and the level multiplies
// an output register holds the result so the next item can be taken while it waits
// asynchronous reset clears all sound state; table valid bits make both tables read as zero
`timescale 1ns / 1ps
`default_nettype none

module wavetable_fm_sound_channel_core (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire wfmsc_pkg::in_item_t in_item,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output wfmsc_pkg::out_item_t     out_item
);

	wfmsc_pkg::ctrl_cmd_t  cmd;
	wfmsc_pkg::dp_status_t status;

	wfmsc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_func   (in_item.func),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	wfmsc_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_item  (in_item),
		.cmd      (cmd),
		.status   (status),
		.out_item (out_item)
	);

endmodule

`default_nettype wire

[sv/wfmsc_ctrl.sv]
// wfmsc_ctrl: sequencer for one item at a time and the output valid flag
// depends on wfmsc_pkg
`timescale 1ns / 1ps
`default_nettype none

module wfmsc_ctrl (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	input  wire logic [1:0]            in_func,
	output logic                       in_ready,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	input  wire wfmsc_pkg::dp_status_t status,
	output wfmsc_pkg::ctrl_cmd_t       cmd
);

	wfmsc_pkg::state_t state_q, state_d;
	logic              out_valid_q, out_valid_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= wfmsc_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		cmd         = '0;
		state_d     = state_q;
		out_valid_d = out_valid_q && !out_ready;
		in_ready    = (state_q == wfmsc_pkg::ST_IDLE);
		case (state_q)
			wfmsc_pkg::ST_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					case (in_func)
						wfmsc_pkg::FUNC_TICK:  state_d = wfmsc_pkg::ST_ENV;
						wfmsc_pkg::FUNC_WRITE: state_d = wfmsc_pkg::ST_BUS;
						wfmsc_pkg::FUNC_READ:  state_d = wfmsc_pkg::ST_BUS;
						default:               state_d = wfmsc_pkg::ST_DONE;
					endcase
				end
			end
			wfmsc_pkg::ST_ENV: begin
				cmd.env = 1'b1;
				state_d = wfmsc_pkg::ST_MOD;
			end
			wfmsc_pkg::ST_MOD: begin
				cmd.modstep = 1'b1;
				// halted or wave write: level stays zero, main phase holds
				state_d = status.silent ? wfmsc_pkg::ST_DONE : wfmsc_pkg::ST_MUL1;
			end
			wfmsc_pkg::ST_MUL1: begin
				cmd.mul1 = 1'b1;
				state_d  = wfmsc_pkg::ST_MUL2;
			end
			wfmsc_pkg::ST_MUL2: begin
				cmd.mul2 = 1'b1;
				state_d  = wfmsc_pkg::ST_PHASE;
			end
			wfmsc_pkg::ST_PHASE: begin
				cmd.phase = 1'b1;
				state_d   = wfmsc_pkg::ST_LEVEL;
			end
			wfmsc_pkg::ST_LEVEL: begin
				cmd.level = 1'b1;
				state_d   = wfmsc_pkg::ST_SCALE;
			end
			wfmsc_pkg::ST_SCALE: begin
				cmd.scale = 1'b1;
				state_d   = wfmsc_pkg::ST_DONE;
			end
			wfmsc_pkg::ST_BUS: begin
				cmd.bus = 1'b1;
				state_d = wfmsc_pkg::ST_DONE;
			end
			wfmsc_pkg::ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.load_out = 1'b1;
					out_valid_d  = 1'b1;
					state_d      = wfmsc_pkg::ST_IDLE;
				end
			end
			default: state_d = wfmsc_pkg::ST_IDLE;
		endcase
	end

	assign out_valid = out_valid_q;

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q != wfmsc_pkg::ST_IDLE))
		else $error("sequencer stayed idle after an input transfer");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == wfmsc_pkg::ST_DONE))
		else $error("output became valid outside the done step");

	a_one_result_per_item: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == wfmsc_pkg::ST_DONE && !out_valid_q) |=> out_valid_q)
		else $error("finished item did not reach the output register");

endmodule

`default_nettype wire

[sv/wfmsc_dp.sv]
// wfmsc_dp: sound registers, wave and modulation tables, envelopes, pitch bend and output level
// depends on wfmsc_pkg; driven by commands from wfmsc_ctrl
`timescale 1ns / 1ps
`default_nettype none

module wfmsc_dp (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire wfmsc_pkg::in_item_t  in_item,
	input  wire wfmsc_pkg::ctrl_cmd_t cmd,
	output wfmsc_pkg::dp_status_t     status,
	output wfmsc_pkg::out_item_t      out_item
);

	localparam int AW    = wfmsc_pkg::TABLE_AW;
	localparam int DEPTH = wfmsc_pkg::TABLE_DEPTH;

	wfmsc_pkg::in_item_t  item_q;
	wfmsc_pkg::out_item_t out_q;

	logic [21:0] main_phase_q, mod_phase_q;
	logic [11:0] pitch_q, mod_pitch_q;
	logic [6:0]  mod_counter_q;
	logic [5:0]  volume_q, volume_speed_q, volume_div_q;
	logic [5:0]  mod_gain_q, gain_speed_q, gain_div_q;
	logic [7:0]  env_speed_q;
	logic [11:0] env_div_q;
	logic [1:0]  atten_q;
	logic [7:0]  flags_q;
	logic        mod_step_q;
	logic [10:0] res_level_q;

	logic signed [19:0] t_s1;
	logic signed [23:0] p_s2;
	logic [11:0]        mix_s3;

	// tables
	logic [5:0]       wave_mem [DEPTH];
	logic [2:0]       mod_mem  [DEPTH];
	logic [DEPTH-1:0] wave_vld_q, mod_vld_q;
	logic [5:0]       wave_rd_q;
	logic [2:0]       mod_rd_q;
	logic             wave_rd_vld_q, mod_rd_vld_q;

	// item decode
	logic       is_write, wave_range, wave_we, wave_re, mod_we;
	logic [AW-1:0] wave_ra, wave_wa;
	logic [5:0] wave_word;
	logic [2:0] mod_word;
	logic [7:0] wd;

	// envelope and modulation terms
	logic        env_run, mod_run, env_expire, vol_expire, gain_expire;
	logic [11:0] env_period;
	logic [12:0] env_next;
	logic [6:0]  vol_next, gain_next;
	logic [21:0] mod_next;
	logic [2:0]  mod_step;
	logic signed [7:0] cnt_sum;
	logic [6:0]  cnt_sat;

	// bend and level terms
	logic signed [20:0] t_adj;
	logic signed [23:0] bend, freq_sum;
	logic        bend_en;
	logic [11:0] freq;
	logic [21:0] main_next;
	logic [5:0]  vol_clip;
	logic [20:0] level_full;

	assign is_write   = (item_q.func == wfmsc_pkg::FUNC_WRITE);
	assign wd         = item_q.bus_data;
	assign wave_range = (item_q.bus_addr >= wfmsc_pkg::ADDR_WAVE_FIRST) &&
		(item_q.bus_addr <= wfmsc_pkg::ADDR_WAVE_LAST);
	assign wave_we    = cmd.bus && is_write && wave_range && flags_q[wfmsc_pkg::FLG_WAV_WRITE];
	assign wave_wa    = item_q.bus_addr[AW-1:0];
	assign wave_re    = cmd.bus || cmd.phase;
	assign wave_ra    = cmd.phase ? main_next[21:16] : item_q.bus_addr[AW-1:0];
	assign mod_we     = cmd.bus && is_write && (item_q.bus_addr == wfmsc_pkg::ADDR_MOD_TABLE) &&
		flags_q[wfmsc_pkg::FLG_MOD_DIS];

	assign wave_word = wave_rd_vld_q ? wave_rd_q : 6'd0;
	assign mod_word  = mod_rd_vld_q ? mod_rd_q : 3'd0;

	assign env_run = !(flags_q[wfmsc_pkg::FLG_WAV_HALT] || flags_q[wfmsc_pkg::FLG_ENV_HALT]);
	assign mod_run = !(flags_q[wfmsc_pkg::FLG_WAV_HALT] || flags_q[wfmsc_pkg::FLG_MOD_DIS]) &&
		(mod_pitch_q != 12'd0);

	assign env_period  = {({4'd0, env_speed_q} + 12'd1)} << 3;
	assign env_next    = {1'b0, env_div_q} + 13'd1;
	assign env_expire  = (env_next >= {1'b0, env_period});
	assign vol_next    = {1'b0, volume_div_q} + 7'd1;
	assign vol_expire  = (vol_next >= {1'b0, volume_speed_q});
	assign gain_next   = {1'b0, gain_div_q} + 7'd1;
	assign gain_expire = (gain_next >= {1'b0, gain_speed_q});
	assign mod_next    = mod_phase_q + {10'd0, mod_pitch_q};

	// counter step with saturation to -64..63
	assign mod_step = mod_word;
	assign cnt_sum  = $signed({mod_counter_q[6], mod_counter_q}) +
		8'(wfmsc_pkg::step_delta(mod_step));
	always_comb begin
		if (cnt_sum > 8'sd63) begin
			cnt_sat = 7'h3F;
		end else if (cnt_sum < -8'sd64) begin
			cnt_sat = 7'h40;
		end else begin
			cnt_sat = cnt_sum[6:0];
		end
	end

	// positive products with a fraction round up by a whole extra step
	always_comb begin
		if (t_s1 > 20'sd0 && t_s1[3:0] != 4'd0) begin
			t_adj = {t_s1[19], t_s1} + 21'sd16;
		end else begin
			t_adj = {t_s1[19], t_s1};
		end
	end

	assign bend     = p_s2 >>> 6;
	assign freq_sum = $signed({12'd0, pitch_q}) + bend;
	assign bend_en  = !flags_q[wfmsc_pkg::FLG_MOD_DIS] && (mod_counter_q != 7'd0);
	always_comb begin
		if (!bend_en) begin
			freq = pitch_q;
		end else if (freq_sum < 24'sd0) begin
			freq = 12'd0;
		end else if (freq_sum > 24'sd4095) begin
			freq = 12'hFFF;
		end else begin
			freq = freq_sum[11:0];
		end
	end
	assign main_next = main_phase_q + {10'd0, freq};

	assign vol_clip   = (volume_q < 6'd32) ? volume_q : 6'd32;
	assign level_full = {9'd0, mix_s3} * {12'd0, wfmsc_pkg::atten_mult(atten_q)};

	assign status.silent = flags_q[wfmsc_pkg::FLG_WAV_HALT] || flags_q[wfmsc_pkg::FLG_WAV_WRITE];

	// table storage
	always_ff @(posedge clk) begin
		if (wave_we) begin
			wave_mem[wave_wa] <= wd[5:0];
		end
		if (wave_re) begin
			wave_rd_q <= wave_mem[wave_ra];
		end
		if (mod_we) begin
			mod_mem[mod_phase_q[21:16]] <= wd[2:0];
		end
		if (cmd.env) begin
			mod_rd_q <= mod_mem[mod_next[21:16]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wave_vld_q    <= '0;
			mod_vld_q     <= '0;
			wave_rd_vld_q <= 1'b0;
			mod_rd_vld_q  <= 1'b0;
		end else begin
			if (wave_we) begin
				wave_vld_q[wave_wa] <= 1'b1;
			end
			if (wave_re) begin
				wave_rd_vld_q <= wave_vld_q[wave_ra];
			end
			if (mod_we) begin
				mod_vld_q[mod_phase_q[21:16]] <= 1'b1;
			end
			if (cmd.env) begin
				mod_rd_vld_q <= mod_vld_q[mod_next[21:16]];
			end
		end
	end

	// arithmetic stage registers
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			item_q <= in_item;
		end
		if (cmd.mul1) begin
			t_s1 <= $signed(mod_counter_q) * $signed({1'b0, pitch_q});
		end
		if (cmd.mul2) begin
			p_s2 <= $signed(t_adj[20:4]) * $signed({1'b0, mod_gain_q});
		end
		if (cmd.level) begin
			mix_s3 <= {6'd0, wave_word} * {6'd0, vol_clip};
		end
		if (cmd.load_out) begin
			out_q.audio_level <= res_level_q;
			out_q.read_data   <= (item_q.func == wfmsc_pkg::FUNC_READ && wave_range) ?
				{2'b00, wave_word} : 8'd0;
		end
	end

	// sound state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_phase_q   <= '0;
			mod_phase_q    <= '0;
			pitch_q        <= '0;
			mod_pitch_q    <= '0;
			mod_counter_q  <= '0;
			volume_q       <= '0;
			volume_speed_q <= '0;
			volume_div_q   <= '0;
			mod_gain_q     <= '0;
			gain_speed_q   <= '0;
			gain_div_q     <= '0;
			env_speed_q    <= '0;
			env_div_q      <= '0;
			atten_q        <= '0;
			flags_q        <= '0;
			mod_step_q     <= 1'b0;
			res_level_q    <= '0;
		end else begin
			if (cmd.accept) begin
				res_level_q <= '0;
			end
			if (cmd.env) begin
				if (env_run) begin
					if (!env_expire) begin
						env_div_q <= env_next[11:0];
					end else begin
						env_div_q <= '0;
						if (!flags_q[wfmsc_pkg::FLG_VOL_DIS]) begin
							if (vol_expire) begin
								volume_div_q <= '0;
								if (flags_q[wfmsc_pkg::FLG_VOL_GROW]) begin
									if (volume_q < 6'd32) volume_q <= volume_q + 6'd1;
								end else if (volume_q != 6'd0) begin
									volume_q <= volume_q - 6'd1;
								end
							end else begin
								volume_div_q <= vol_next[5:0];
							end
						end
						if (!flags_q[wfmsc_pkg::FLG_GAIN_DIS]) begin
							if (gain_expire) begin
								gain_div_q <= '0;
								if (flags_q[wfmsc_pkg::FLG_GAIN_GROW]) begin
									if (mod_gain_q < 6'd63) mod_gain_q <= mod_gain_q + 6'd1;
								end else if (mod_gain_q != 6'd0) begin
									mod_gain_q <= mod_gain_q - 6'd1;
								end
							end else begin
								gain_div_q <= gain_next[5:0];
							end
						end
					end
				end
				if (mod_run) begin
					mod_phase_q <= mod_next;
					mod_step_q  <= (mod_next[21:16] != mod_phase_q[21:16]);
				end else begin
					mod_step_q <= 1'b0;
				end
			end
			if (cmd.modstep && mod_step_q) begin
				if (mod_step == wfmsc_pkg::STEP_RESET) begin
					mod_counter_q <= '0;
				end else begin
					mod_counter_q <= cnt_sat;
				end
			end
			if (cmd.phase) begin
				main_phase_q <= main_next;
			end
			if (cmd.scale) begin
				res_level_q <= level_full[18:8];
			end
			if (cmd.bus && is_write) begin
				case (item_q.bus_addr)
					wfmsc_pkg::ADDR_VOL_ENV: begin
						flags_q[wfmsc_pkg::FLG_VOL_DIS]  <= wd[7];
						flags_q[wfmsc_pkg::FLG_VOL_GROW] <= wd[6];
						volume_speed_q <= wd[5:0];
						if (wd[7]) volume_q <= wd[5:0];
					end
					wfmsc_pkg::ADDR_PITCH_LO: pitch_q[7:0] <= wd;
					wfmsc_pkg::ADDR_PITCH_HI: begin
						pitch_q[11:8] <= wd[3:0];
						flags_q[wfmsc_pkg::FLG_WAV_HALT] <= wd[7];
						flags_q[wfmsc_pkg::FLG_ENV_HALT] <= wd[6];
						if (wd[7]) env_div_q <= '0;
					end
					wfmsc_pkg::ADDR_GAIN_ENV: begin
						flags_q[wfmsc_pkg::FLG_GAIN_DIS]  <= wd[7];
						flags_q[wfmsc_pkg::FLG_GAIN_GROW] <= wd[6];
						gain_speed_q <= wd[5:0];
						if (wd[7]) mod_gain_q <= wd[5:0];
					end
					wfmsc_pkg::ADDR_MOD_CNT: mod_counter_q <= wd[6:0];
					wfmsc_pkg::ADDR_MOD_LO:  mod_pitch_q[7:0] <= wd;
					wfmsc_pkg::ADDR_MOD_HI: begin
						mod_pitch_q[11:8] <= wd[3:0];
						flags_q[wfmsc_pkg::FLG_MOD_DIS] <= wd[7];
						if (wd[7]) mod_phase_q <= '0;
					end
					wfmsc_pkg::ADDR_MOD_TABLE: begin
						// table load walks the modulation position
						if (flags_q[wfmsc_pkg::FLG_MOD_DIS]) begin
							mod_phase_q[21:16] <= mod_phase_q[21:16] + 6'd1;
						end
					end
					wfmsc_pkg::ADDR_WAVE_CTRL: begin
						flags_q[wfmsc_pkg::FLG_WAV_WRITE] <= wd[7];
						atten_q <= wd[1:0];
					end
					wfmsc_pkg::ADDR_ENV_SPEED: begin
						env_speed_q <= wd;
						env_div_q   <= '0;
					end
					default: begin
					end
				endcase
			end
		end
	end

	assign out_item = out_q;

	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scale |=> (res_level_q <= 11'd2016))
		else $error("scaled level out of range");

	a_main_phase_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.modstep && status.silent) |=> $stable(main_phase_q))
		else $error("main phase moved while halted or in wave write");

	a_volume_grow_cap: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.env && volume_q <= 6'd32) |=> (volume_q <= 6'd32))
		else $error("volume envelope passed its ceiling");

endmodule

`default_nettype wire

[tb/sv/wavetable_fm_sound_channel_core_tb.sv]
// self-checking testbench for wavetable_fm_sound_channel_core: directed and random bus and tick items
// a clocked driver and monitor around a local channel model; depends on wfmsc_pkg and the core
`timescale 1ns / 1ps

module wavetable_fm_sound_channel_core_tb;
	import wfmsc_pkg::*;

	localparam logic [1:0]  FUNC_UNUSED   = 2'd3;
	localparam logic [15:0] ADDR_UNMAPPED = 16'h4081;
	localparam int          RANDOM_ITEMS  = 1750;
	localparam int          HOLD_SPACING  = 450;
	localparam int          DRAIN_CYCLES  = 16;
	localparam int          CYCLE_LIMIT   = 800000;

	localparam int SWEEP_DELTA [8] = '{0, 1, 2, 4, 0, -4, -3, -1};
	localparam int ATTEN_SCALE [4] = '{256, 171, 128, 102};
	localparam logic [15:0] REG_MAP [11] = '{ADDR_VOL_ENV, ADDR_UNMAPPED, ADDR_PITCH_LO,
		ADDR_PITCH_HI, ADDR_GAIN_ENV, ADDR_MOD_CNT, ADDR_MOD_LO, ADDR_MOD_HI, ADDR_MOD_TABLE,
		ADDR_WAVE_CTRL, ADDR_ENV_SPEED};

	typedef struct packed {
		logic     hold;
		in_item_t item;
	} stim_t;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_ready;
	in_item_t  in_item = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	out_item_t out_item;

	stim_t     stim_q[$];
	out_item_t expected_out[$];
	int        n_items = 0;
	int        accepted_cnt = 0;
	int        err_cnt = 0;
	int        cycle_cnt = 0;
	logic      calm = 1'b0;

	// channel model state
	logic [5:0]  wave_mem [64];
	logic [2:0]  sweep_mem [64];
	logic [21:0] ph_main, ph_mod;
	logic [11:0] pitch_r, modpitch_r;
	logic [6:0]  sweep_cnt;
	logic [5:0]  vol_r, vol_spd, vol_div;
	logic [5:0]  gain_r, gain_spd, gain_div;
	logic [7:0]  env_spd;
	logic [11:0] env_div;
	logic [1:0]  atten_r;
	logic [7:0]  flags;

	wavetable_fm_sound_channel_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

	always #5 clk = ~clk;

	function automatic void reset_model();
		for (int i = 0; i < 64; i++) begin
			wave_mem[i] = '0;
			sweep_mem[i] = '0;
		end
		ph_main = '0;
		ph_mod = '0;
		pitch_r = '0;
		modpitch_r = '0;
		sweep_cnt = '0;
		vol_r = '0;
		vol_spd = '0;
		vol_div = '0;
		gain_r = '0;
		gain_spd = '0;
		gain_div = '0;
		env_spd = '0;
		env_div = '0;
		atten_r = '0;
		flags = '0;
	endfunction

	function automatic void clock_envelopes();
		int period;
		int d;
		period = (int'(env_spd) + 1) * 8;
		d = int'(env_div) + 1;
		if (d < period) begin
			env_div = 12'(d);
			return;
		end
		env_div = '0;
		if (!flags[FLG_VOL_DIS]) begin
			d = int'(vol_div) + 1;
			if (d >= int'(vol_spd)) begin
				vol_div = '0;
				if (flags[FLG_VOL_GROW]) begin
					if (vol_r < 6'd32)
						vol_r++;
				end else if (vol_r > 6'd0)
					vol_r--;
			end else
				vol_div = 6'(d);
		end
		if (!flags[FLG_GAIN_DIS]) begin
			d = int'(gain_div) + 1;
			if (d >= int'(gain_spd)) begin
				gain_div = '0;
				if (flags[FLG_GAIN_GROW]) begin
					if (gain_r < 6'd63)
						gain_r++;
				end else if (gain_r > 6'd0)
					gain_r--;
			end else
				gain_div = 6'(d);
		end
	endfunction

	function automatic void step_sweep();
		logic [5:0] old_pos;
		logic [2:0] step;
		int         c;
		old_pos = ph_mod[21:16];
		ph_mod = ph_mod + 22'(modpitch_r);
		if (ph_mod[21:16] != old_pos) begin
			step = sweep_mem[ph_mod[21:16]];
			if (step == STEP_RESET)
				sweep_cnt = '0;
			else begin
				c = int'($signed(sweep_cnt)) + SWEEP_DELTA[step];
				if (c > 63)
					c = 63;
				if (c < -64)
					c = -64;
				sweep_cnt = 7'(c);
			end
		end
	endfunction

	function automatic logic [10:0] sample_tick();
		int freq;
		int cnt;
		int t;
		int vol;
		if (!(flags[FLG_WAV_HALT] || flags[FLG_ENV_HALT]))
			clock_envelopes();
		if (!(flags[FLG_WAV_HALT] || flags[FLG_MOD_DIS]) && modpitch_r != 12'd0)
			step_sweep();
		if (flags[FLG_WAV_WRITE] || flags[FLG_WAV_HALT])
			return '0;
		freq = int'(pitch_r);
		cnt = int'($signed(sweep_cnt));
		if (!flags[FLG_MOD_DIS] && cnt != 0) begin
			t = cnt * freq;
			// positive products with a fraction round up before the floor shift
			if (t > 0 && (t & 15) != 0)
				t += 16;
			t = t >>> 4;
			t = (t * int'(gain_r)) >>> 6;
			freq = freq + t;
			if (freq < 0)
				freq = 0;
			if (freq > 4095)
				freq = 4095;
		end
		ph_main = ph_main + 22'(freq);
		vol = (vol_r < 6'd32) ? int'(vol_r) : 32;
		return 11'((int'(wave_mem[ph_main[21:16]]) * vol * ATTEN_SCALE[atten_r]) >> 8);
	endfunction

	function automatic void apply_write(input logic [15:0] a, input logic [7:0] v);
		if (a >= ADDR_WAVE_FIRST && a <= ADDR_WAVE_LAST) begin
			if (flags[FLG_WAV_WRITE])
				wave_mem[a[5:0]] = v[5:0];
			return;
		end
		case (a)
			ADDR_VOL_ENV: begin
				flags[FLG_VOL_DIS] = v[7];
				flags[FLG_VOL_GROW] = v[6];
				vol_spd = v[5:0];
				if (flags[FLG_VOL_DIS])
					vol_r = vol_spd;
			end
			ADDR_PITCH_LO: pitch_r[7:0] = v;
			ADDR_PITCH_HI: begin
				pitch_r[11:8] = v[3:0];
				flags[FLG_WAV_HALT] = v[7];
				flags[FLG_ENV_HALT] = v[6];
				if (flags[FLG_WAV_HALT])
					env_div = '0;
			end
			ADDR_GAIN_ENV: begin
				flags[FLG_GAIN_DIS] = v[7];
				flags[FLG_GAIN_GROW] = v[6];
				gain_spd = v[5:0];
				if (flags[FLG_GAIN_DIS])
					gain_r = gain_spd;
			end
			ADDR_MOD_CNT: sweep_cnt = v[6:0];
			ADDR_MOD_LO: modpitch_r[7:0] = v;
			ADDR_MOD_HI: begin
				modpitch_r[11:8] = v[3:0];
				flags[FLG_MOD_DIS] = v[7];
				if (flags[FLG_MOD_DIS])
					ph_mod = '0;
			end
			ADDR_MOD_TABLE: begin
				// table loads only while modulation is off, one entry per write
				if (flags[FLG_MOD_DIS]) begin
					sweep_mem[ph_mod[21:16]] = v[2:0];
					ph_mod = ph_mod + 22'h10000;
				end
			end
			ADDR_WAVE_CTRL: begin
				flags[FLG_WAV_WRITE] = v[7];
				atten_r = v[1:0];
			end
			ADDR_ENV_SPEED: begin
				env_spd = v;
				env_div = '0;
			end
			default: ;
		endcase
	endfunction

	function automatic out_item_t predict_item(input in_item_t it);
		out_item_t r;
		r = '0;
		case (it.func)
			FUNC_TICK: r.audio_level = sample_tick();
			FUNC_WRITE: apply_write(it.bus_addr, it.bus_data);
			FUNC_READ: begin
				if (it.bus_addr >= ADDR_WAVE_FIRST && it.bus_addr <= ADDR_WAVE_LAST)
					r.read_data = {2'b00, wave_mem[it.bus_addr[5:0]]};
			end
			default: ;
		endcase
		return r;
	endfunction

	// stimulus construction
	task automatic push_item(input logic [1:0] f, input logic [15:0] a, input logic [7:0] d);
		stim_t s;
		s.hold = 1'b0;
		s.item.func = f;
		s.item.bus_addr = a;
		s.item.bus_data = d;
		stim_q.push_back(s);
		n_items++;
	endtask

	task automatic push_hold();
		stim_t s;
		s = '0;
		s.hold = 1'b1;
		stim_q.push_back(s);
	endtask

	function automatic logic [7:0] reg_value(input logic [15:0] a);
		logic [7:0] v;
		v = 8'($urandom);
		case (a)
			ADDR_VOL_ENV, ADDR_GAIN_ENV: begin
				if ($urandom_range(0, 1) == 0)
					v[5:0] = 6'($urandom_range(0, 3));
			end
			ADDR_PITCH_HI: begin
				v[7] = ($urandom_range(0, 5) == 0);
				v[6] = ($urandom_range(0, 5) == 0);
			end
			ADDR_MOD_HI: v[7] = ($urandom_range(0, 4) == 0);
			ADDR_WAVE_CTRL: v[7] = ($urandom_range(0, 5) == 0);
			ADDR_ENV_SPEED: begin
				if ($urandom_range(0, 3) != 0)
					v = 8'($urandom_range(0, 3));
			end
			default: ;
		endcase
		return v;
	endfunction

	task automatic push_ticks(input int n);
		repeat (n) begin
			if ($urandom_range(0, 11) == 0)
				push_item(FUNC_READ, ADDR_WAVE_FIRST + 16'($urandom_range(0, 63)), 8'($urandom));
			else
				push_item(FUNC_TICK, 16'($urandom), 8'($urandom));
		end
	endtask

	// driver: one transfer per accepted item, random gaps between items
	stim_t    head;
	logic     next_valid;
	in_item_t next_item;
	int       idle_left;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_item <= '0;
			idle_left = 0;
			reset_model();
		end else begin
			next_valid = in_valid;
			next_item = in_item;
			if (in_valid && in_ready) begin
				expected_out.push_back(predict_item(in_item));
				accepted_cnt++;
				next_valid = 1'b0;
				if (!calm && $urandom_range(0, 3) == 0)
					idle_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
						: $urandom_range(1, 3);
			end
			if (!next_valid) begin
				if (idle_left > 0)
					idle_left--;
				else if (stim_q.size() > 0) begin
					if (stim_q[0].hold) begin
						// sender holds off until every result is back
						if (expected_out.size() == 0)
							head = stim_q.pop_front();
					end else begin
						head = stim_q.pop_front();
						next_item = head.item;
						next_valid = 1'b1;
					end
				end
			end
			in_valid <= next_valid;
			in_item <= next_item;
		end
	end

	// monitor: checks each result transfer, random back-pressure
	out_item_t want;
	int        ready_left;

	task automatic flag_mismatch(input string what, input out_item_t exp_v, input out_item_t got);
		if (err_cnt < 10)
			$display("%0t: %s: expected level %0d data %0d, got level %0d data %0d", $realtime,
				what, exp_v.audio_level, exp_v.read_data, got.audio_level, got.read_data);
		err_cnt++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			ready_left = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_out.size() == 0)
					flag_mismatch("unexpected result", '0, out_item);
				else begin
					want = expected_out.pop_front();
					if (out_item.audio_level !== want.audio_level
							|| out_item.read_data !== want.read_data)
						flag_mismatch("result mismatch", want, out_item);
				end
			end
			if (ready_left > 0)
				ready_left--;
			else if (calm || $urandom_range(0, 2) != 0) begin
				out_ready <= 1'b1;
				ready_left = $urandom_range(1, 12);
			end else begin
				out_ready <= 1'b0;
				ready_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
					: $urandom_range(0, 3);
			end
		end
	end

	// watchdog, and stretches where neither side idles
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt[7:0] == 8'hFF)
			calm <= ($urandom_range(0, 3) == 0);
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		int          pick;
		int          n;
		int          base;
		int          next_hold;
		int          total;
		logic [15:0] a;

		// directed: reset values, table access, extremes, halt and unused code
		push_item(FUNC_TICK, 16'h0000, 8'h00);
		push_item(FUNC_READ, ADDR_WAVE_FIRST, 8'h00);
		push_item(FUNC_WRITE, ADDR_WAVE_CTRL, 8'h80);
		push_item(FUNC_WRITE, ADDR_WAVE_FIRST, 8'hFF);
		push_item(FUNC_WRITE, ADDR_WAVE_LAST, 8'h2A);
		push_item(FUNC_READ, ADDR_WAVE_FIRST, 8'hFF);
		push_item(FUNC_READ, ADDR_WAVE_LAST, 8'h00);
		push_item(FUNC_READ, ADDR_WAVE_FIRST - 16'd1, 8'h00);
		push_item(FUNC_READ, ADDR_VOL_ENV, 8'h00);
		push_item(FUNC_WRITE, ADDR_UNMAPPED, 8'hFF);
		push_item(FUNC_WRITE, 16'hFFFF, 8'hFF);
		push_item(FUNC_WRITE, ADDR_VOL_ENV, 8'hBF);
		push_item(FUNC_WRITE, ADDR_PITCH_LO, 8'hFF);
		push_item(FUNC_WRITE, ADDR_PITCH_HI, 8'h0F);
		push_item(FUNC_TICK, 16'hFFFF, 8'hFF);
		push_item(FUNC_WRITE, ADDR_WAVE_CTRL, 8'h03);
		push_item(FUNC_WRITE, ADDR_MOD_HI, 8'h80);
		push_item(FUNC_WRITE, ADDR_MOD_TABLE, 8'h03);
		push_item(FUNC_WRITE, ADDR_MOD_TABLE, {5'd0, STEP_RESET});
		push_item(FUNC_WRITE, ADDR_GAIN_ENV, 8'hBF);
		push_item(FUNC_WRITE, ADDR_MOD_CNT, 8'h40);
		push_item(FUNC_WRITE, ADDR_MOD_LO, 8'hFF);
		push_item(FUNC_WRITE, ADDR_MOD_HI, 8'h0F);
		push_item(FUNC_TICK, 16'h0000, 8'h00);
		push_item(FUNC_WRITE, ADDR_ENV_SPEED, 8'hFF);
		push_item(FUNC_WRITE, ADDR_PITCH_HI, 8'hC0);
		push_item(FUNC_TICK, 16'h0000, 8'h00);
		push_item(FUNC_UNUSED, 16'hFFFF, 8'hFF);
		push_hold();

		next_hold = n_items + HOLD_SPACING;
		total = n_items + RANDOM_ITEMS;
		while (n_items < total) begin
			if (n_items >= next_hold) begin
				push_hold();
				next_hold += HOLD_SPACING;
			end
			pick = $urandom_range(0, 9);
			if (pick <= 5) begin
				repeat ($urandom_range(1, 5)) begin
					a = REG_MAP[$urandom_range(0, 10)];
					push_item(FUNC_WRITE, a, reg_value(a));
				end
				case ($urandom_range(0, 3))
					0: begin
						// wave table load: enter write mode, fill a run, read back, then mostly leave
						push_item(FUNC_WRITE, ADDR_WAVE_CTRL, {1'b1, 7'($urandom)});
						n = $urandom_range(4, 64);
						base = $urandom_range(0, 63);
						for (int k = 0; k < n; k++)
							push_item(FUNC_WRITE, ADDR_WAVE_FIRST + 16'((base + k) % 64),
								8'($urandom));
						repeat (2)
							push_item(FUNC_READ, ADDR_WAVE_FIRST + 16'($urandom_range(0, 63)),
								8'($urandom));
						push_item(FUNC_WRITE, ADDR_WAVE_CTRL,
							{($urandom_range(0, 7) == 0), 7'($urandom)});
					end
					1: begin
						// modulation table load with modulation off, then mostly re-enable
						push_item(FUNC_WRITE, ADDR_MOD_HI, {1'b1, 7'($urandom)});
						repeat ($urandom_range(1, 64))
							push_item(FUNC_WRITE, ADDR_MOD_TABLE, 8'($urandom));
						push_item(FUNC_WRITE, ADDR_MOD_LO, 8'($urandom));
						push_item(FUNC_WRITE, ADDR_MOD_HI,
							{($urandom_range(0, 7) == 0), 7'($urandom)});
					end
					default: ;
				endcase
				push_ticks($urandom_range(8, 60));
			end else if (pick <= 7)
				push_ticks($urandom_range(5, 40));
			else if (pick == 8) begin
				repeat ($urandom_range(1, 10)) begin
					a = ($urandom_range(0, 1) == 0) ? 16'($urandom)
						: 16'($urandom_range(16'h4030, 16'h409F));
					push_item(2'($urandom_range(0, 3)), a, 8'($urandom));
				end
			end else begin
				repeat ($urandom_range(1, 6))
					push_item(FUNC_READ, 16'($urandom_range(16'h4030, 16'h408F)), 8'($urandom));
			end
		end

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (accepted_cnt != n_items || expected_out.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (err_cnt == 0 && expected_out.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

[sim.f]
sv/wfmsc_pkg.sv
sv/wfmsc_ctrl.sv
sv/wfmsc_dp.sv
sv/wavetable_fm_sound_channel_core.sv
tb/sv/wavetable_fm_sound_channel_core_tb.sv
